// ----- rtl/lkt_pkg.sv -----
// lkt_pkg: shared types and constants of the lru key table
// no dependencies; imported by lkt_cell and lru_key_table
package lkt_pkg;

  localparam int unsigned KEY_W = 64;
  localparam int unsigned CNT_W = 32;
  localparam int unsigned CFG_W = 5;
  localparam int unsigned OCC_W = 5;

  localparam logic [CFG_W-1:0] MAX_ENTRIES_RST = 5'd16;

  typedef enum logic [1:0] {
    MODE_LOOKUP = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_CLEAR  = 2'd3
  } lkt_mode_e;

  typedef struct packed {
    logic clear;
    logic load;
    logic shift;
  } lkt_cell_ctrl_t;

endpackage

// ----- rtl/lkt_cell.sv -----
// lkt_cell: one entry of the recency chain, key, valid flag and key compare
// depends on lkt_pkg; its place in the chain is its recency rank
module lkt_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  lkt_pkg::lkt_cell_ctrl_t   ctrl_i,
  input  logic [lkt_pkg::KEY_W-1:0] new_key_i,
  input  logic [lkt_pkg::KEY_W-1:0] next_key_i,
  input  logic                      next_valid_i,
  input  logic [lkt_pkg::KEY_W-1:0] cmp_key_i,
  output logic [lkt_pkg::KEY_W-1:0] key_o,
  output logic                      valid_o,
  output logic                      match_o
);
  import lkt_pkg::*;

  logic [KEY_W-1:0] key_q;
  logic             valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.load) begin
      valid_q <= 1'b1;
    end else if (ctrl_i.shift) begin
      valid_q <= next_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      key_q <= new_key_i;
    end else if (ctrl_i.shift) begin
      key_q <= next_key_i;
    end
  end

  assign key_o   = key_q;
  assign valid_o = valid_q;
  assign match_o = valid_q && (key_q == cmp_key_i);

endmodule

// ----- rtl/lru_key_table.sv -----
// lru_key_table: fully associative key table in least-recently-used order
// depends on lkt_pkg and lkt_cell
//
// A request is taken whenever start is high; busy stays low, so one request
// can be issued every clock cycle. The request is registered and executed in
// the next cycle against all cells at once. Its result is on the result ports
// with done_o in the cycle after the execution cycle, for exactly one
// cycle. The receiver cannot stall. Cells are ordered by age, cell 0 the
// oldest, and shift toward cell 0 when an entry leaves or moves up to newest.
// The limit register is only taken while the table is empty.
module lru_key_table #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                mode_i,
  input  logic [lkt_pkg::KEY_W-1:0] key_i,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [lkt_pkg::CFG_W-1:0] cfg_data_i,
  output logic                      done_o,
  output logic                      hit_o,
  output logic                      inserted_o,
  output logic                      evicted_o,
  output logic [lkt_pkg::KEY_W-1:0] evicted_key_o,
  output logic [lkt_pkg::OCC_W-1:0] occupancy_o,
  output logic [lkt_pkg::CNT_W-1:0] hit_count_o,
  output logic [lkt_pkg::CNT_W-1:0] miss_count_o,
  output logic [lkt_pkg::CNT_W-1:0] evict_count_o
);
  import lkt_pkg::*;

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned HW = $clog2(CAPACITY + 1);
  localparam int unsigned CW = (HW > CFG_W) ? HW : CFG_W;

  // request register
  logic             req_vld_q;
  lkt_mode_e        req_mode_q;
  logic [KEY_W-1:0] req_key_q;

  logic [CFG_W-1:0] max_q;
  logic [HW-1:0]    held_q, held_d;
  logic [CNT_W-1:0] hit_cnt_q, hit_cnt_d;
  logic [CNT_W-1:0] miss_cnt_q, miss_cnt_d;
  logic [CNT_W-1:0] evict_cnt_q, evict_cnt_d;

  logic             done_q;
  logic             hit_q, hit_d;
  logic             ins_q, ins_d;
  logic             evc_q, evc_d;
  logic [KEY_W-1:0] evc_key_q, evc_key_d;

  logic [CAPACITY-1:0][KEY_W-1:0] cell_key;
  logic [CAPACITY-1:0]            cell_valid;
  logic [CAPACITY-1:0]            cell_match;
  lkt_cell_ctrl_t [CAPACITY-1:0]  cell_ctrl;

  logic          any_hit;
  logic [IW-1:0] hit_pos;
  logic [CW-1:0] limit;
  logic          full;
  logic [HW-1:0] held_m1;

  logic          shift_en, load_en, clear_en;
  logic [HW-1:0] shift_lo, shift_hi, load_pos;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    hit_pos = '0;
    for (int unsigned i = 0; i < CAPACITY; i++) begin
      if (cell_match[i]) begin
        hit_pos = hit_pos | IW'(i);
      end
    end
  end

  assign any_hit = |cell_match;
  assign held_m1 = held_q - 1'b1;

  always_comb begin
    limit = CW'(max_q);
    if (limit == '0) begin
      limit = CW'(1);
    end else if (limit > CW'(CAPACITY)) begin
      limit = CW'(CAPACITY);
    end
  end

  assign full = CW'(held_q) >= limit;

  always_comb begin
    shift_en    = 1'b0;
    load_en     = 1'b0;
    clear_en    = 1'b0;
    shift_lo    = '0;
    shift_hi    = '0;
    load_pos    = '0;
    held_d      = held_q;
    hit_cnt_d   = hit_cnt_q;
    miss_cnt_d  = miss_cnt_q;
    evict_cnt_d = evict_cnt_q;
    hit_d       = 1'b0;
    ins_d       = 1'b0;
    evc_d       = 1'b0;
    evc_key_d   = '0;
    if (req_vld_q) begin
      case (req_mode_q)
        MODE_LOOKUP: begin
          hit_d = any_hit;
          if (any_hit) begin
            hit_cnt_d = hit_cnt_q + 1'b1;
          end else begin
            miss_cnt_d = miss_cnt_q + 1'b1;
          end
        end
        MODE_INSERT: begin
          if (any_hit) begin
            // move the matching entry up to newest
            hit_d     = 1'b1;
            hit_cnt_d = hit_cnt_q + 1'b1;
            shift_en  = 1'b1;
            shift_lo  = HW'(hit_pos);
            shift_hi  = held_m1;
            load_en   = 1'b1;
            load_pos  = held_m1;
          end else begin
            miss_cnt_d = miss_cnt_q + 1'b1;
            ins_d      = 1'b1;
            load_en    = 1'b1;
            if (full) begin
              // oldest leaves from cell 0
              evc_d       = 1'b1;
              evc_key_d   = cell_key[0];
              evict_cnt_d = evict_cnt_q + 1'b1;
              shift_en    = 1'b1;
              shift_lo    = '0;
              shift_hi    = held_m1;
              load_pos    = held_m1;
            end else begin
              load_pos = held_q;
              held_d   = held_q + 1'b1;
            end
          end
        end
        MODE_REMOVE: begin
          if (any_hit) begin
            hit_d    = 1'b1;
            shift_en = 1'b1;
            shift_lo = HW'(hit_pos);
            shift_hi = held_q;
            held_d   = held_m1;
          end
        end
        MODE_CLEAR: begin
          clear_en = 1'b1;
          held_d   = '0;
        end
        default: begin
          clear_en = 1'b0;
        end
      endcase
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [KEY_W-1:0] next_key;
    logic             next_valid;

    if (g == CAPACITY - 1) begin : g_top
      assign next_key   = '0;
      assign next_valid = 1'b0;
    end else begin : g_mid
      assign next_key   = cell_key[g+1];
      assign next_valid = cell_valid[g+1];
    end

    assign cell_ctrl[g].clear = clear_en;
    assign cell_ctrl[g].load  = load_en && (HW'(g) == load_pos);
    assign cell_ctrl[g].shift = shift_en && (HW'(g) >= shift_lo) && (HW'(g) < shift_hi);

    lkt_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (cell_ctrl[g]),
      .new_key_i    (req_key_q),
      .next_key_i   (next_key),
      .next_valid_i (next_valid),
      .cmp_key_i    (req_key_q),
      .key_o        (cell_key[g]),
      .valid_o      (cell_valid[g]),
      .match_o      (cell_match[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q   <= 1'b0;
      max_q       <= MAX_ENTRIES_RST;
      held_q      <= '0;
      hit_cnt_q   <= '0;
      miss_cnt_q  <= '0;
      evict_cnt_q <= '0;
      done_q      <= 1'b0;
    end else begin
      req_vld_q   <= start && !busy;
      held_q      <= held_d;
      hit_cnt_q   <= hit_cnt_d;
      miss_cnt_q  <= miss_cnt_d;
      evict_cnt_q <= evict_cnt_d;
      done_q      <= req_vld_q;
      if (cfg_valid_i && cfg_ready_o && (held_q == '0)) begin
        max_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      req_mode_q <= lkt_mode_e'(mode_i);
      req_key_q  <= key_i;
    end
    if (req_vld_q) begin
      hit_q     <= hit_d;
      ins_q     <= ins_d;
      evc_q     <= evc_d;
      evc_key_q <= evc_key_d;
    end
  end

  assign done_o        = done_q;
  assign hit_o         = hit_q;
  assign inserted_o    = ins_q;
  assign evicted_o     = evc_q;
  assign evicted_key_o = evc_key_q;
  assign occupancy_o   = OCC_W'(held_q);
  assign hit_count_o   = hit_cnt_q;
  assign miss_count_o  = miss_cnt_q;
  assign evict_count_o = evict_cnt_q;

endmodule

// ----- verif/tb_lru_key_table.sv -----
// tb_lru_key_table: self-checking testbench for the lru key table
// predicts every result with its own table model and compares on done_o
// depends on lkt_pkg and lru_key_table
`timescale 1ns / 100ps

module tb_lru_key_table;
  import lkt_pkg::*;

  localparam int unsigned CAPACITY    = 16;
  localparam int unsigned STALL_LIMIT = 4000;

  typedef struct packed {
    logic             hit;
    logic             inserted;
    logic             evicted;
    logic [KEY_W-1:0] evicted_key;
    logic [OCC_W-1:0] occupancy;
    logic [CNT_W-1:0] hit_count;
    logic [CNT_W-1:0] miss_count;
    logic [CNT_W-1:0] evict_count;
  } lkt_result_t;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             start       = 1'b0;
  logic [1:0]       mode_i      = MODE_LOOKUP;
  logic [KEY_W-1:0] key_i       = '0;
  logic             cfg_valid_i = 1'b0;
  logic [CFG_W-1:0] cfg_data_i  = '0;
  logic             busy;
  logic             cfg_ready_o;
  logic             done_o;
  logic             hit_o;
  logic             inserted_o;
  logic             evicted_o;
  logic [KEY_W-1:0] evicted_key_o;
  logic [OCC_W-1:0] occupancy_o;
  logic [CNT_W-1:0] hit_count_o;
  logic [CNT_W-1:0] miss_count_o;
  logic [CNT_W-1:0] evict_count_o;

  lru_key_table #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .mode_i       (mode_i),
    .key_i        (key_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .done_o       (done_o),
    .hit_o        (hit_o),
    .inserted_o   (inserted_o),
    .evicted_o    (evicted_o),
    .evicted_key_o(evicted_key_o),
    .occupancy_o  (occupancy_o),
    .hit_count_o  (hit_count_o),
    .miss_count_o (miss_count_o),
    .evict_count_o(evict_count_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // shadow copy of the table
  logic [KEY_W-1:0] tbl_key   [CAPACITY];
  bit               tbl_valid [CAPACITY];
  int unsigned      tbl_rank  [CAPACITY];
  int unsigned      tbl_held  = 0;
  logic [CNT_W-1:0] tot_hit   = '0;
  logic [CNT_W-1:0] tot_miss  = '0;
  logic [CNT_W-1:0] tot_evict = '0;
  logic [CFG_W-1:0] limit_reg = MAX_ENTRIES_RST;

  lkt_result_t      pending_results [$];
  logic [KEY_W-1:0] key_pool [32];
  int unsigned      pool_n = 4;
  int               mismatches = 0;
  int unsigned      stall_cycles = 0;

  function automatic void age_down(input int unsigned r);
    for (int i = 0; i < CAPACITY; i++)
      if (tbl_valid[i] && tbl_rank[i] > r) tbl_rank[i]--;
  endfunction

  function automatic void drop_entry(input int s);
    int unsigned r;
    r = tbl_rank[s];
    tbl_valid[s] = 1'b0;
    tbl_rank[s]  = 0;
    age_down(r);
    if (tbl_held > 0) tbl_held--;
  endfunction

  function automatic lkt_result_t lru_apply(input lkt_mode_e m, input logic [KEY_W-1:0] k);
    lkt_result_t r;
    int          s;
    int          o;
    int unsigned lim;
    r = '0;
    s = -1;
    o = -1;
    for (int i = CAPACITY - 1; i >= 0; i--)
      if (tbl_valid[i] && tbl_key[i] == k) s = i;
    lim = (limit_reg == 0) ? 1 : ((limit_reg > CAPACITY) ? CAPACITY : limit_reg);
    case (m)
      MODE_LOOKUP: begin
        if (s >= 0) begin
          r.hit = 1'b1;
          tot_hit++;
        end else begin
          tot_miss++;
        end
      end
      MODE_INSERT: begin
        if (s >= 0) begin
          r.hit = 1'b1;
          tot_hit++;
          age_down(tbl_rank[s]);
          tbl_rank[s] = tbl_held - 1;
        end else begin
          tot_miss++;
          r.inserted = 1'b1;
          if (tbl_held >= lim) begin
            for (int i = CAPACITY - 1; i >= 0; i--)
              if (tbl_valid[i] && tbl_rank[i] == 0) o = i;
            if (o >= 0) begin
              r.evicted     = 1'b1;
              r.evicted_key = tbl_key[o];
              tot_evict++;
              drop_entry(o);
            end
          end
          s = -1;
          for (int i = CAPACITY - 1; i >= 0; i--)
            if (!tbl_valid[i]) s = i;
          if (s >= 0) begin
            tbl_key[s]   = k;
            tbl_valid[s] = 1'b1;
            tbl_rank[s]  = tbl_held;
            tbl_held++;
          end
        end
      end
      MODE_REMOVE: begin
        if (s >= 0) begin
          r.hit = 1'b1;
          drop_entry(s);
        end
      end
      default: begin
        for (int i = 0; i < CAPACITY; i++) begin
          tbl_valid[i] = 1'b0;
          tbl_rank[i]  = 0;
        end
        tbl_held = 0;
      end
    endcase
    r.occupancy   = tbl_held[OCC_W-1:0];
    r.hit_count   = tot_hit;
    r.miss_count  = tot_miss;
    r.evict_count = tot_evict;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [KEY_W-1:0] exp_v,
                                      input logic [KEY_W-1:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endfunction

  always @(posedge clk_i) begin
    lkt_result_t exp_r;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: result with no request pending", $time);
      end else begin
        exp_r = pending_results.pop_front();
        check_field("hit", exp_r.hit, hit_o);
        check_field("inserted", exp_r.inserted, inserted_o);
        check_field("evicted", exp_r.evicted, evicted_o);
        check_field("evicted_key", exp_r.evicted_key, evicted_key_o);
        check_field("occupancy", exp_r.occupancy, occupancy_o);
        check_field("hit_count", exp_r.hit_count, hit_count_o);
        check_field("miss_count", exp_r.miss_count, miss_count_o);
        check_field("evict_count", exp_r.evict_count, evict_count_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // start stays high on return so back-to-back requests need no gap
  task automatic send_request(input lkt_mode_e m, input logic [KEY_W-1:0] k);
    start  <= 1'b1;
    mode_i <= m;
    key_i  <= k;
    do @(posedge clk_i); while (busy);
    pending_results.push_back(lru_apply(m, k));
  endtask

  task automatic idle_cycles(input int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // bounded form gives up if the table holds cfg_ready_o low
  task automatic write_limit(input logic [CFG_W-1:0] v, input bit bounded);
    int tries = 0;
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do begin
      @(posedge clk_i);
      tries++;
    end while (!cfg_ready_o && !(bounded && tries >= 16));
    if (cfg_ready_o && tbl_held == 0) limit_reg = v;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_single_entry_limit();
    write_limit(5'd0, 1'b0);
    send_request(MODE_INSERT, '0);
    send_request(MODE_INSERT, '1);
    send_request(MODE_LOOKUP, '0);
    send_request(MODE_LOOKUP, '1);
    send_request(MODE_INSERT, '1);
    send_request(MODE_REMOVE, '0);
    send_request(MODE_REMOVE, '1);
    wait_drained();
  endtask

  task automatic test_clamp_and_clear();
    write_limit(5'd31, 1'b0);
    send_request(MODE_INSERT, 64'h0123_4567_89ab_cdef);
    send_request(MODE_INSERT, 64'hfedc_ba98_7654_3210);
    send_request(MODE_INSERT, 64'h8000_0000_0000_0001);
    send_request(MODE_INSERT, 64'h0123_4567_89ab_cdef);
    wait_drained();
    // table not empty, so this write must not take effect
    write_limit(5'd1, 1'b1);
    send_request(MODE_INSERT, 64'h5555_aaaa_5555_aaaa);
    send_request(MODE_LOOKUP, 64'hfedc_ba98_7654_3210);
    send_request(MODE_CLEAR, '1);
    send_request(MODE_LOOKUP, 64'h0123_4567_89ab_cdef);
    wait_drained();
  endtask

  task automatic test_refresh_order();
    write_limit(5'd2, 1'b0);
    send_request(MODE_INSERT, 64'h11);
    send_request(MODE_INSERT, 64'h22);
    send_request(MODE_INSERT, 64'h11);
    send_request(MODE_INSERT, 64'h33);
    send_request(MODE_LOOKUP, 64'h11);
    send_request(MODE_LOOKUP, 64'h22);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int unsigned idle_pct);
    int unsigned pick;
    lkt_mode_e   m;
    logic [KEY_W-1:0] k;
    for (int ph = 0; ph < 3; ph++) begin
      send_request(MODE_CLEAR, {$urandom, $urandom});
      wait_drained();
      case ($urandom_range(5))
        0:       write_limit(5'd0, 1'b0);
        1:       write_limit(5'd1, 1'b0);
        2:       write_limit(5'd16, 1'b0);
        3:       write_limit(5'd31, 1'b0);
        4:       write_limit(5'd17, 1'b0);
        default: write_limit(CFG_W'($urandom_range(31)), 1'b0);
      endcase
      pool_n = $urandom_range(2, 24);
      for (int i = 0; i < 32; i++) key_pool[i] = {$urandom, $urandom};
      key_pool[0] = $urandom_range(1) ? '0 : '1;
      for (int n = 0; n < 137; n++) begin
        pick = $urandom_range(99);
        if (pick < 35)      m = MODE_LOOKUP;
        else if (pick < 78) m = MODE_INSERT;
        else if (pick < 98) m = MODE_REMOVE;
        else                m = MODE_CLEAR;
        if ($urandom_range(99) < 75) k = key_pool[$urandom_range(pool_n - 1)];
        else                          k = {$urandom, $urandom};
        send_request(m, k);
        if ($urandom_range(99) == 0) wait_drained();
        else while ($urandom_range(99) < idle_pct) idle_cycles(1);
      end
    end
    wait_drained();
  endtask

  initial begin
    for (int i = 0; i < CAPACITY; i++) begin
      tbl_key[i]   = '0;
      tbl_valid[i] = 1'b0;
      tbl_rank[i]  = 0;
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_single_entry_limit();
    test_clamp_and_clear();
    test_refresh_order();
    test_random_traffic(28);
    test_random_traffic(55);
    test_random_traffic(0);
    wait_drained();
    repeat (6) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- lru_key_table.f -----
rtl/lkt_pkg.sv
rtl/lkt_cell.sv
rtl/lru_key_table.sv
verif/tb_lru_key_table.sv
